### hw/rtl/birds_eye_pixel_remap_unit_assert.svh
// Assertion helpers shared by the remap unit RTL.
`ifndef BIRDS_EYE_PIXEL_REMAP_UNIT_ASSERT_SVH
`define BIRDS_EYE_PIXEL_REMAP_UNIT_ASSERT_SVH

// cond must hold at every edge outside reset
`define BEPR_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons must hold in the cycle after ante
`define BEPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/bepr_pkg.sv
package bepr_pkg;

    localparam int IMAGE_COLS = 1920;
    localparam int IMAGE_ROWS = 1080;

    localparam int COORD_W    = 11;
    localparam int PIX_W      = 24;
    localparam int FOCAL_W    = 20;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VANISH_ROW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_HEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_SINE    = 3'd6;

    localparam logic [FOCAL_W-1:0] FOCAL_X_RST       = 20'd409600;
    localparam logic [FOCAL_W-1:0] FOCAL_Y_RST       = 20'd409600;
    localparam logic [CFG_W-1:0]   CENTER_X_RST      = 16'd15360;
    localparam logic [CFG_W-1:0]   CENTER_Y_RST      = 16'd8640;
    localparam logic [CFG_W-1:0]   VANISH_ROW_RST    = 16'd8640;
    localparam logic [CFG_W-1:0]   CAMERA_HEIGHT_RST = 16'd6144;
    localparam logic [CFG_W-1:0]   PITCH_SINE_RST    = 16'd2858;

    // quotient bits of the two dividers
    localparam int QB = $clog2((IMAGE_COLS > IMAGE_ROWS) ? IMAGE_COLS : IMAGE_ROWS);

    localparam int QDEPTH = 4;
    localparam int QA_W   = $clog2(QDEPTH);

    // datapath widths
    localparam int D16_W  = 16;
    localparam int DIF_W  = 17;
    localparam int B_W    = 32;
    localparam int F_W    = 36;
    localparam int FH_W   = F_W / 2;
    localparam int PR_W   = 34;
    localparam int P_W    = 57;
    localparam int CREM_W = P_W - 1;
    localparam int C100_W = 23;
    localparam int Q_W    = 43;
    localparam int QC_W   = Q_W + $clog2(IMAGE_COLS + 1);
    localparam int E_W    = 37;
    localparam int DP_W   = E_W + FH_W;
    localparam int D_W    = DP_W + FH_W;
    localparam int DL_W   = 37;
    localparam int YV_W   = 17;
    localparam int TL_W   = DL_W + YV_W;
    localparam int TH_W   = (D_W - DL_W) + YV_W;
    localparam int T_W    = 90;
    localparam int MAG_W  = 32;
    localparam int MH_W   = MAG_W + CFG_W;
    localparam int N0_W   = MH_W + FOCAL_W;
    localparam int NSH    = 17;
    localparam int N16_W  = N0_W + NSH;
    localparam int DEN_W  = D_W + 4;
    localparam int DENR_W = DEN_W + $clog2(IMAGE_ROWS + 1);
    localparam int NUM_W  = T_W + 1;

    typedef struct packed {
        logic [FOCAL_W-1:0] fx;
        logic [FOCAL_W-1:0] fy;
        logic [CFG_W-1:0]   cx;
        logic [CFG_W-1:0]   cy;
        logic [CFG_W-1:0]   vr;
        logic [CFG_W-1:0]   ch;
        logic [CFG_W-1:0]   ps;
    } t_cfg;

    typedef struct packed {
        logic                    ok;
        logic [D16_W-1:0]        d16;
        logic signed [DIF_W-1:0] du;
        logic signed [DIF_W-1:0] dv;
        logic [PIX_W-1:0]        pix;
    } t_item;

    typedef struct packed {
        logic              ok;
        logic [CREM_W-1:0] p;
        logic [Q_W-1:0]    q;
        logic [NUM_W-1:0]  num;
        logic [DEN_W-1:0]  den;
        logic [PIX_W-1:0]  pix;
    } t_mid;

endpackage

### hw/rtl/bepr_if.sv
interface bepr_in_if import bepr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] src_col;
    logic [COORD_W-1:0] src_row;
    logic [PIX_W-1:0]   pixel_value;

    modport source(output valid, src_col, src_row, pixel_value, input ready);
    modport sink(input valid, src_col, src_row, pixel_value, output ready);
endinterface

interface bepr_out_if import bepr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] dst_col;
    logic [COORD_W-1:0] dst_row;
    logic [PIX_W-1:0]   pixel_out;
    logic               write_enable;

    modport source(output valid, dst_col, dst_row, pixel_out, write_enable, input ready);
    modport sink(input valid, dst_col, dst_row, pixel_out, write_enable, output ready);
endinterface

interface bepr_cfg_if import bepr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

### hw/rtl/birds_eye_pixel_remap_unit.sv
// Bird's-eye pixel remap: one source pixel in, one destination result out.
// Throughput: one pixel per clock, sustained; math and divider stages stall together on
//   output backpressure while the front register and 4-entry queue absorb up to 5 transfers.
// Path from input transfer to output valid: front register, queue, 8 multiply/compare stages,
//   then one restoring-divider stage per quotient bit (11 here).
// Reset: synchronous, active low; clears pipeline valids and queue, loads register defaults.

module birds_eye_pixel_remap_unit import bepr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bepr_cfg_if.sink   i_cfg,
    bepr_in_if.sink    i_in,
    bepr_out_if.source o_out
);

    t_cfg  r_cfg;
    logic  w_f_valid;
    t_item w_f_item;
    logic  w_q_ready;
    logic  w_q_valid;
    t_item w_q_item;
    logic  w_adv;
    logic  w_pop;
    logic  w_m_valid;
    t_mid  w_m_mid;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fx <= FOCAL_X_RST;
            r_cfg.fy <= FOCAL_Y_RST;
            r_cfg.cx <= CENTER_X_RST;
            r_cfg.cy <= CENTER_Y_RST;
            r_cfg.vr <= VANISH_ROW_RST;
            r_cfg.ch <= CAMERA_HEIGHT_RST;
            r_cfg.ps <= PITCH_SINE_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_FOCAL_X:       r_cfg.fx <= i_cfg.data[FOCAL_W-1:0];
                REG_FOCAL_Y:       r_cfg.fy <= i_cfg.data[FOCAL_W-1:0];
                REG_CENTER_X:      r_cfg.cx <= i_cfg.data[CFG_W-1:0];
                REG_CENTER_Y:      r_cfg.cy <= i_cfg.data[CFG_W-1:0];
                REG_VANISH_ROW:    r_cfg.vr <= i_cfg.data[CFG_W-1:0];
                REG_CAMERA_HEIGHT: r_cfg.ch <= i_cfg.data[CFG_W-1:0];
                REG_PITCH_SINE:    r_cfg.ps <= i_cfg.data[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    bepr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .o_valid (w_f_valid),
        .o_item  (w_f_item),
        .i_ready (w_q_ready)
    );

    bepr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .i_item  (w_f_item),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_adv)
    );

    assign w_pop = w_adv && w_q_valid;

    bepr_math u_math (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_pop),
        .i_item  (w_q_item),
        .i_cfg   (r_cfg),
        .o_valid (w_m_valid),
        .o_mid   (w_m_mid)
    );

    bepr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_m_valid),
        .i_mid   (w_m_mid),
        .o_adv   (w_adv),
        .o_out   (o_out)
    );

endmodule

### hw/rtl/bepr_front.sv
module bepr_front import bepr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    bepr_in_if.sink  i_in,
    output logic     o_valid,
    output t_item    o_item,
    input  logic     i_ready
);

    logic                    r_valid;
    t_item                   r_item;
    t_item                   n_item;
    logic signed [DIF_W-1:0] w_d16;

    assign i_in.ready = !r_valid || i_ready;

    always_comb begin
        w_d16      = $signed({2'b00, i_in.src_row, 4'b0000}) - $signed({1'b0, i_cfg.vr});
        n_item.du  = $signed({2'b00, i_in.src_col, 4'b0000}) - $signed({1'b0, i_cfg.cx});
        n_item.dv  = $signed({1'b0, i_cfg.cy}) - $signed({2'b00, i_in.src_row, 4'b0000});
        n_item.d16 = w_d16[D16_W-1:0];
        n_item.pix = i_in.pixel_value;
        n_item.ok  = (w_d16 > 0) && (32'(i_in.src_col) < IMAGE_COLS)
                     && (32'(i_in.src_row) < IMAGE_ROWS)
                     && (i_cfg.ps != '0) && (i_cfg.fx != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### hw/rtl/bepr_queue.sv
module bepr_queue import bepr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

`include "birds_eye_pixel_remap_unit_assert.svh"

    t_item           r_mem [QDEPTH];
    logic [QA_W-1:0] r_wp;
    logic [QA_W-1:0] r_rp;
    logic [QA_W:0]   r_cnt;
    logic            w_push;
    logic            w_pop;

    assign o_ready = r_cnt != (QA_W + 1)'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && o_valid;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    `BEPR_ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_cnt <= (QA_W + 1)'(QDEPTH), "queue overfull")
    `BEPR_ASSERT_NEXT(a_cnt_inc, i_clk, i_rst_n, w_push && !w_pop, r_cnt == $past(r_cnt) + 1'b1, "queue count did not grow")
    `BEPR_ASSERT_NEXT(a_cnt_dec, i_clk, i_rst_n, w_pop && !w_push, r_cnt == $past(r_cnt) - 1'b1, "queue count did not shrink")

endmodule

### hw/rtl/bepr_math.sv
module bepr_math import bepr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_item i_item,
    input  t_cfg  i_cfg,
    output logic  o_valid,
    output t_mid  o_mid
);

    logic [7:0] r_v;

    logic signed [DIF_W-1:0] w_c0;
    logic [YV_W-1:0]         w_yv;
    logic [C100_W-1:0]       w_c100;

    // stage 1
    logic                   r1_ok;
    logic [B_W-1:0]         r1_b;
    logic [F_W-1:0]         r1_f;
    logic signed [PR_W-1:0] r1_a;
    logic signed [PR_W-1:0] r1_m;
    logic [PIX_W-1:0]       r1_pix;
    // stage 2
    logic                   r2_ok;
    logic signed [P_W-1:0]  r2_p1;
    logic signed [P_W-1:0]  r2_p2;
    logic [Q_W-1:0]         r2_q;
    logic [E_W-1:0]         r2_e;
    logic [F_W-1:0]         r2_f;
    logic                   r2_neg;
    logic [MAG_W-1:0]       r2_mag;
    logic [PIX_W-1:0]       r2_pix;
    // stage 3
    logic                   r3_ok;
    logic signed [P_W-1:0]  r3_p;
    logic [QC_W-1:0]        r3_qc;
    logic [Q_W-1:0]         r3_q;
    logic [DP_W-1:0]        r3_dlo;
    logic [DP_W-1:0]        r3_dhi;
    logic [MH_W-1:0]        r3_mh;
    logic                   r3_neg;
    logic [PIX_W-1:0]       r3_pix;
    // stage 4
    logic                   r4_cok;
    logic [CREM_W-1:0]      r4_p;
    logic [Q_W-1:0]         r4_q;
    logic [D_W-1:0]         r4_d;
    logic [N0_W-1:0]        r4_n0;
    logic                   r4_neg;
    logic [PIX_W-1:0]       r4_pix;
    // stage 5
    logic                   r5_cok;
    logic [CREM_W-1:0]      r5_p;
    logic [Q_W-1:0]         r5_q;
    logic [TL_W-1:0]        r5_tlo;
    logic [TH_W-1:0]        r5_thi;
    logic [N16_W-1:0]       r5_n16;
    logic [DEN_W-1:0]       r5_den;
    logic                   r5_neg;
    logic [PIX_W-1:0]       r5_pix;
    // stage 6
    logic                   r6_cok;
    logic [CREM_W-1:0]      r6_p;
    logic [Q_W-1:0]         r6_q;
    logic [T_W-1:0]         r6_t1;
    logic [N16_W-1:0]       r6_n16;
    logic [DEN_W-1:0]       r6_den;
    logic [DENR_W-1:0]      r6_denr;
    logic                   r6_neg;
    logic [PIX_W-1:0]       r6_pix;
    // stage 7
    logic                   r7_ok;
    logic [CREM_W-1:0]      r7_p;
    logic [Q_W-1:0]         r7_q;
    logic [NUM_W-1:0]       r7_num;
    logic [DEN_W-1:0]       r7_den;
    logic [DENR_W-1:0]      r7_denr;
    logic [PIX_W-1:0]       r7_pix;
    // stage 8
    t_mid                   r8_mid;

    assign w_c0   = $signed({1'b0, i_cfg.cy}) - $signed({1'b0, i_cfg.vr});
    assign w_yv   = {1'b0, i_cfg.cy} + {1'b0, i_cfg.vr};
    assign w_c100 = C100_W'(i_cfg.cx) * C100_W'(100);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[6:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ok  <= i_item.ok;
            r1_b   <= B_W'(i_item.d16) * B_W'(i_cfg.ps);
            r1_f   <= F_W'(i_cfg.fx) * F_W'(i_cfg.ps);
            r1_a   <= PR_W'(w_c0) * PR_W'(i_item.du);
            r1_m   <= PR_W'(w_c0) * PR_W'(i_item.dv);
            r1_pix <= i_item.pix;

            r2_ok  <= r1_ok;
            r2_p1  <= (P_W'(r1_a) * P_W'($signed({1'b0, i_cfg.ch}))) <<< 4;
            r2_p2  <= $signed(P_W'(w_c100) * P_W'(r1_b));
            r2_q   <= Q_W'(r1_b) * Q_W'(1600);
            r2_e   <= E_W'(r1_b) * E_W'(25);
            r2_f   <= r1_f;
            r2_neg <= r1_m[PR_W-1];
            r2_mag <= r1_m[PR_W-1] ? MAG_W'(-r1_m) : MAG_W'(r1_m);
            r2_pix <= r1_pix;

            r3_ok  <= r2_ok;
            r3_p   <= r2_p1 + r2_p2;
            r3_qc  <= QC_W'(r2_q) * QC_W'(IMAGE_COLS);
            r3_q   <= r2_q;
            r3_dlo <= DP_W'(r2_e) * DP_W'(r2_f[FH_W-1:0]);
            r3_dhi <= DP_W'(r2_e) * DP_W'(r2_f[F_W-1:FH_W]);
            r3_mh  <= MH_W'(r2_mag) * MH_W'(i_cfg.ch);
            r3_neg <= r2_neg;
            r3_pix <= r2_pix;

            // column lands strictly inside the frame
            r4_cok <= r3_ok && !r3_p[P_W-1] && (r3_p != '0)
                      && (r3_p[P_W-2:0] < (P_W - 1)'(r3_qc));
            r4_p   <= r3_p[CREM_W-1:0];
            r4_q   <= r3_q;
            r4_d   <= D_W'(r3_dlo) + (D_W'(r3_dhi) << FH_W);
            r4_n0  <= N0_W'(r3_mh) * N0_W'(i_cfg.fy);
            r4_neg <= r3_neg;
            r4_pix <= r3_pix;

            r5_cok <= r4_cok;
            r5_p   <= r4_p;
            r5_q   <= r4_q;
            r5_tlo <= TL_W'(r4_d[DL_W-1:0]) * TL_W'(w_yv);
            r5_thi <= TH_W'(r4_d[D_W-1:DL_W]) * TH_W'(w_yv);
            r5_n16 <= N16_W'(r4_n0) << NSH;
            r5_den <= DEN_W'(r4_d) << 4;
            r5_neg <= r4_neg;
            r5_pix <= r4_pix;

            r6_cok  <= r5_cok;
            r6_p    <= r5_p;
            r6_q    <= r5_q;
            r6_t1   <= T_W'(r5_tlo) + (T_W'(r5_thi) << DL_W);
            r6_n16  <= r5_n16;
            r6_den  <= r5_den;
            r6_denr <= DENR_W'(r5_den) * DENR_W'(IMAGE_ROWS);
            r6_neg  <= r5_neg;
            r6_pix  <= r5_pix;

            r7_ok   <= r6_cok && (r6_neg || (T_W'(r6_n16) < r6_t1));
            r7_p    <= r6_p;
            r7_q    <= r6_q;
            r7_num  <= r6_neg ? NUM_W'(r6_t1) + NUM_W'(r6_n16)
                              : NUM_W'(r6_t1) - NUM_W'(r6_n16);
            r7_den  <= r6_den;
            r7_denr <= r6_denr;
            r7_pix  <= r6_pix;

            r8_mid.ok  <= r7_ok && (r7_num != '0) && (r7_num < NUM_W'(r7_denr));
            r8_mid.p   <= r7_p;
            r8_mid.q   <= r7_q;
            r8_mid.num <= r7_num;
            r8_mid.den <= r7_den;
            r8_mid.pix <= r7_pix;
        end
    end

    assign o_valid = r_v[7];
    assign o_mid   = r8_mid;

endmodule

### hw/rtl/bepr_div.sv
module bepr_div import bepr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_mid       i_mid,
    output logic       o_adv,
    bepr_out_if.source o_out
);

`include "birds_eye_pixel_remap_unit_assert.svh"

    logic [QB-1:0]     r_v;
    logic [CREM_W-1:0] r_crem [QB];
    logic [QB-1:0]     r_cq   [QB];
    logic [Q_W-1:0]    r_q    [QB];
    logic [NUM_W-1:0]  r_rrem [QB];
    logic [QB-1:0]     r_rq   [QB];
    logic [DEN_W-1:0]  r_den  [QB];
    logic              r_ok   [QB];
    logic [PIX_W-1:0]  r_pix  [QB];

    assign o_adv = !r_v[QB-1] || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (o_adv) begin
            r_v <= {r_v[QB-2:0], i_valid};
        end
    end

    // restoring division, one quotient bit per stage, MSB first
    for (genvar k = 0; k < QB; k++) begin : g_stage
        localparam int SH = QB - 1 - k;

        logic [CREM_W-1:0] w_crem;
        logic [QB-1:0]     w_cq;
        logic [Q_W-1:0]    w_q;
        logic [NUM_W-1:0]  w_rrem;
        logic [QB-1:0]     w_rq;
        logic [DEN_W-1:0]  w_den;
        logic              w_ok;
        logic [PIX_W-1:0]  w_pix;
        logic [CREM_W-1:0] w_cdiv;
        logic [NUM_W-1:0]  w_rdiv;
        logic              w_csub;
        logic              w_rsub;

        if (k == 0) begin : g_first
            assign w_crem = i_mid.p;
            assign w_cq   = '0;
            assign w_q    = i_mid.q;
            assign w_rrem = i_mid.num;
            assign w_rq   = '0;
            assign w_den  = i_mid.den;
            assign w_ok   = i_mid.ok;
            assign w_pix  = i_mid.pix;
        end else begin : g_next
            assign w_crem = r_crem[k-1];
            assign w_cq   = r_cq[k-1];
            assign w_q    = r_q[k-1];
            assign w_rrem = r_rrem[k-1];
            assign w_rq   = r_rq[k-1];
            assign w_den  = r_den[k-1];
            assign w_ok   = r_ok[k-1];
            assign w_pix  = r_pix[k-1];
        end

        assign w_cdiv = CREM_W'(w_q) << SH;
        assign w_rdiv = NUM_W'(w_den) << SH;
        assign w_csub = w_crem >= w_cdiv;
        assign w_rsub = w_rrem >= w_rdiv;

        always_ff @(posedge i_clk) begin
            if (o_adv) begin
                r_crem[k] <= w_csub ? w_crem - w_cdiv : w_crem;
                r_cq[k]   <= w_cq | (QB'(w_csub) << SH);
                r_rrem[k] <= w_rsub ? w_rrem - w_rdiv : w_rrem;
                r_rq[k]   <= w_rq | (QB'(w_rsub) << SH);
                r_q[k]    <= w_q;
                r_den[k]  <= w_den;
                r_ok[k]   <= w_ok;
                r_pix[k]  <= w_pix;
            end
        end
    end

    assign o_out.valid        = r_v[QB-1];
    assign o_out.dst_col      = r_ok[QB-1] ? COORD_W'(r_cq[QB-1]) : '0;
    assign o_out.dst_row      = r_ok[QB-1] ? COORD_W'(r_rq[QB-1]) : '0;
    assign o_out.pixel_out    = r_pix[QB-1];
    assign o_out.write_enable = r_ok[QB-1];

    `BEPR_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_out.valid && !o_out.ready, $stable(r_v), "pipeline moved while output stalled")

endmodule
